[src/pmnap_pkg.sv]
// Shared types and codes for the palette matcher and nibble atlas packer.
// No dependencies.
package pmnap_pkg;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_PIXEL = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam int TILES_W     = 11;
    localparam int COLORS_W    = 5;
    localparam int COLORS_RST  = 16;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] read_row;
        logic [8:0] read_column;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]         read_byte;
        logic [3:0]         color_index;
        logic               color_missing;
        logic               outside_atlas;
        logic [TILES_W-1:0] tiles_placed;
    } out_beat_t;

    typedef struct packed {
        logic [COLORS_W-1:0] color_count;
    } cfg_beat_t;

endpackage

[src/pmnap_chan_if.sv]
// Valid/ready channel carrying one payload beat.
// Payload type is set per instance; used with the pmnap_pkg beat types.
interface pmnap_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/palette_match_nibble_atlas_packer.sv]
// Palette matcher and 4-bit tile atlas packer, top level.
// Depends on pmnap_pkg and pmnap_chan_if.
//
// Channels: cmd (sink, in_beat_t) takes palette loads, pixels in tile raster
// order and atlas byte reads. rsp (source, out_beat_t) returns one beat per
// cmd beat, in order. cfg (sink, cfg_beat_t) writes the active color count;
// always ready; it must be written only while the block is idle, which the block does not enforce.
// Throughput: one cmd beat per cycle while cmd.ready is high. The palette
// compare runs on all entries in parallel at the input; the atlas byte then
// goes through a read-modify-write on one synchronous RAM (address stage,
// read, merge and write), with the previous write forwarded when the same
// byte is hit. A result beat passes the s1, s2 and s3 registers and is then
// held in an 8-deep output FIFO.
// Stall: cmd.ready drops when FIFO entries plus beats in flight reach the
// FIFO depth; the pipeline itself never stops.
// Reset: palette, cursor and tile count clear at once; the atlas RAM is then
// cleared one byte a cycle, all ATLAS_ROWS * ATLAS_BYTES_PER_ROW bytes
// (153600 at default size), with cmd.ready low throughout.
module palette_match_nibble_atlas_packer
    import pmnap_pkg::*;
#(
    parameter int TILE_WIDTH          = 16,
    parameter int TILE_HEIGHT         = 16,
    parameter int ATLAS_BYTES_PER_ROW = 320,
    parameter int ATLAS_ROWS          = 480,
    parameter int PALETTE_DEPTH       = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    pmnap_chan_if.sink   cmd,
    pmnap_chan_if.source rsp,
    pmnap_chan_if.sink   cfg
);

    localparam int HALF_TILE  = TILE_WIDTH / 2;
    localparam int GRID_COLS  = (ATLAS_BYTES_PER_ROW + HALF_TILE - 1) / HALF_TILE;
    localparam int GRID_ROWS  = (ATLAS_ROWS + TILE_HEIGHT - 1) / TILE_HEIGHT;
    localparam int GRID_RAW   = GRID_COLS * GRID_ROWS;
    localparam int GRID_CAP   = (GRID_RAW > 2047) ? 2047 : GRID_RAW;
    localparam int MEM_DEPTH  = ATLAS_ROWS * ATLAS_BYTES_PER_ROW;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int ROW_W      = $clog2(ATLAS_ROWS + TILE_HEIGHT + 1);
    localparam int COL_W      = $clog2(ATLAS_BYTES_PER_ROW + HALF_TILE + 1);
    localparam int TRB_W      = $clog2(ATLAS_ROWS + 1);
    localparam int TBC_W      = $clog2(ATLAS_BYTES_PER_ROW);
    localparam int PCOL_W     = (TILE_WIDTH > 1) ? $clog2(TILE_WIDTH) : 1;
    localparam int PROW_W     = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
    localparam int PAL_W      = $clog2(PALETTE_DEPTH);

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         idx;
        logic               miss;
        logic               outside;
        logic               odd;
        logic               in_range;
        logic [TILES_W-1:0] tiles;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } stage_t;

    // configuration and palette
    logic [COLORS_W-1:0] colors_reg;
    logic [23:0]         palette_reg [PALETTE_DEPTH];

    // cursor
    logic [TBC_W-1:0]   tbc_reg, tbc_next;
    logic [TRB_W-1:0]   trb_reg, trb_next;
    logic [PCOL_W-1:0]  pcol_reg, pcol_next;
    logic [PROW_W-1:0]  prow_reg, prow_next;
    logic [TILES_W-1:0] tiles_reg, tiles_next;

    // pipeline
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    stage_t             s0, s1_reg, s2_reg, s3_reg;
    logic [ADDR_W-1:0]  s2_addr_reg, s3_addr_reg;

    // atlas RAM
    logic [7:0]         atlas_mem [MEM_DEPTH];
    logic [7:0]         mem_q_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;
    logic               clr_active_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [7:0]         fwd_data_reg;

    // output FIFO
    out_beat_t             fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    logic                cmd_fire, pixel_fire, pop;
    logic [COLORS_W-1:0] n_active;
    logic [3:0]          match_idx;
    logic                match_found;
    logic [ROW_W-1:0]    depth_row;
    logic [COL_W-1:0]    pix_col;
    logic                pix_outside;
    logic                rd_in_range;
    logic [7:0]          old_byte;
    logic                s3_write;
    out_beat_t           s3_beat;
    logic [FIFO_CNT_W-1:0] in_flight;

    assign in_flight  = FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(s2_valid_reg)
                      + FIFO_CNT_W'(s3_valid_reg);
    assign cmd.ready  = !clr_active_reg
                      && ((count_reg + in_flight) < FIFO_CNT_W'(FIFO_DEPTH));
    assign cfg.ready  = 1'b1;
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign pixel_fire = cmd_fire && (cmd.payload.action == ACT_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_reg <= COLORS_W'(COLORS_RST);
        end
        else if (cfg.valid)
        begin
            colors_reg <= cfg.payload.color_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PALETTE_DEPTH; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else if (cmd_fire && (cmd.payload.action == ACT_LOAD)
                 && (5'(cmd.payload.entry_index) < 5'(PALETTE_DEPTH)))
        begin
            palette_reg[cmd.payload.entry_index[PAL_W-1:0]] <=
                {cmd.payload.red, cmd.payload.green, cmd.payload.blue};
        end
    end

    // lowest matching entry among the active ones
    always_comb
    begin
        n_active    = (colors_reg > COLORS_W'(PALETTE_DEPTH))
                    ? COLORS_W'(PALETTE_DEPTH) : colors_reg;
        match_found = 1'b0;
        match_idx   = '0;
        for (int c = PALETTE_DEPTH - 1; c >= 0; c--)
        begin
            if ((COLORS_W'(c) < n_active) && (palette_reg[c] ==
                {cmd.payload.red, cmd.payload.green, cmd.payload.blue}))
            begin
                match_found = 1'b1;
                match_idx   = 4'(c);
            end
        end
    end

    always_comb
    begin
        depth_row   = ROW_W'(trb_reg) + ROW_W'(prow_reg);
        pix_col     = COL_W'(tbc_reg) + COL_W'(pcol_reg >> 1);
        pix_outside = (depth_row >= ROW_W'(ATLAS_ROWS))
                   || (pix_col >= COL_W'(ATLAS_BYTES_PER_ROW));
        rd_in_range = (32'(cmd.payload.read_row) < ATLAS_ROWS)
                   && (32'(cmd.payload.read_column) < ATLAS_BYTES_PER_ROW);

        s0          = '0;
        s0.action   = cmd.payload.action;
        s0.tiles    = tiles_next;
        unique case (cmd.payload.action)
            ACT_PIXEL:
            begin
                s0.idx     = match_found ? match_idx : n_active[3:0];
                s0.miss    = !match_found;
                s0.outside = pix_outside;
                s0.odd     = pcol_reg[0];
                if (!pix_outside)
                begin
                    s0.row = ROW_W'(ATLAS_ROWS - 1) - depth_row;
                    s0.col = pix_col;
                end
            end
            ACT_READ:
            begin
                s0.in_range = rd_in_range;
                if (rd_in_range)
                begin
                    s0.row = ROW_W'(cmd.payload.read_row);
                    s0.col = COL_W'(cmd.payload.read_column);
                end
            end
            default:
            begin
                s0.in_range = 1'b0;
            end
        endcase
    end

    // cursor advance
    always_comb
    begin
        tbc_next   = tbc_reg;
        trb_next   = trb_reg;
        pcol_next  = pcol_reg;
        prow_next  = prow_reg;
        tiles_next = tiles_reg;
        if (pixel_fire)
        begin
            if (pcol_reg == PCOL_W'(TILE_WIDTH - 1))
            begin
                pcol_next = '0;
                if (prow_reg == PROW_W'(TILE_HEIGHT - 1))
                begin
                    prow_next = '0;
                    if (tiles_reg < TILES_W'(GRID_CAP))
                    begin
                        tiles_next = tiles_reg + 1'b1;
                    end
                    if ((COL_W'(tbc_reg) + COL_W'(HALF_TILE))
                        >= COL_W'(ATLAS_BYTES_PER_ROW))
                    begin
                        tbc_next = '0;
                        if ((ROW_W'(trb_reg) + ROW_W'(TILE_HEIGHT))
                            > ROW_W'(ATLAS_ROWS))
                        begin
                            trb_next = TRB_W'(ATLAS_ROWS);
                        end
                        else
                        begin
                            trb_next = TRB_W'(ROW_W'(trb_reg) + ROW_W'(TILE_HEIGHT));
                        end
                    end
                    else
                    begin
                        tbc_next = TBC_W'(COL_W'(tbc_reg) + COL_W'(HALF_TILE));
                    end
                end
                else
                begin
                    prow_next = prow_reg + 1'b1;
                end
            end
            else
            begin
                pcol_next = pcol_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbc_reg   <= '0;
            trb_reg   <= '0;
            pcol_reg  <= '0;
            prow_reg  <= '0;
            tiles_reg <= '0;
        end
        else
        begin
            tbc_reg   <= tbc_next;
            trb_reg   <= trb_next;
            pcol_reg  <= pcol_next;
            prow_reg  <= prow_next;
            tiles_reg <= tiles_next;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s0;
        s2_reg      <= s1_reg;
        s2_addr_reg <= ADDR_W'(s1_reg.row * ADDR_W'(ATLAS_BYTES_PER_ROW) + s1_reg.col);
        s3_reg      <= s2_reg;
        s3_addr_reg <= s2_addr_reg;
    end

    // merge stage
    always_comb
    begin
        old_byte = (fwd_valid_reg && (fwd_addr_reg == s3_addr_reg))
                 ? fwd_data_reg : mem_q_reg;
        s3_write = s3_valid_reg && (s3_reg.action == ACT_PIXEL) && !s3_reg.outside;

        s3_beat               = '0;
        s3_beat.color_index   = s3_reg.idx;
        s3_beat.color_missing = s3_reg.miss;
        s3_beat.outside_atlas = s3_reg.outside;
        s3_beat.tiles_placed  = s3_reg.tiles;
        if ((s3_reg.action == ACT_READ) && s3_reg.in_range)
        begin
            s3_beat.read_byte = old_byte;
        end

        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s3_write;
            mem_waddr = s3_addr_reg;
            mem_wdata = s3_reg.odd ? (old_byte | {4'b0000, s3_reg.idx})
                                   : {s3_reg.idx, 4'b0000};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            atlas_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= atlas_mem[s2_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            fwd_valid_reg <= s3_write && !clr_active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= s3_addr_reg;
        fwd_data_reg <= mem_wdata;
    end

    // output FIFO
    assign pop         = rsp.valid && rsp.ready;
    assign rsp.valid   = (count_reg != '0);
    assign rsp.payload = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            fifo_mem[wr_ptr_reg] <= s3_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s3_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CNT_W'(s3_valid_reg) - FIFO_CNT_W'(pop);
        end
    end

endmodule

[src/pmnap_checker.sv]
// Port-level assertions for palette_match_nibble_atlas_packer, with bind.
// Depends on pmnap_pkg.
module pmnap_checker
    import pmnap_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_beat_t rsp_payload
);

    logic [FIFO_CNT_W:0]  pending_reg;
    logic [TILES_W-1:0]   last_tiles_reg;
    logic                 seen_reg;
    logic                 cmd_beat, rsp_beat;

    assign cmd_beat = cmd_valid && cmd_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_tiles_reg <= '0;
            seen_reg       <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + (FIFO_CNT_W + 1)'(cmd_beat)
                         - (FIFO_CNT_W + 1)'(rsp_beat);
            if (rsp_beat)
            begin
                last_tiles_reg <= rsp_payload.tiles_placed;
                seen_reg       <= 1'b1;
            end
        end
    end

    a_no_unrequested_beat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != '0))
        else $error("result beat without an outstanding command");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
        else $error("more beats in flight than output buffer holds");

    a_tiles_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_beat && seen_reg) |-> (rsp_payload.tiles_placed >= last_tiles_reg))
        else $error("tile count went backwards");

    a_read_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_payload.read_byte != 8'd0)) |->
        ((rsp_payload.color_index == 4'd0) && !rsp_payload.color_missing
         && !rsp_payload.outside_atlas))
        else $error("read beat carries pixel fields");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
        else $error("stalled result beat changed");

endmodule

bind palette_match_nibble_atlas_packer pmnap_checker u_pmnap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
